### design/palette_pixel_decoder_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef PALETTE_PIXEL_DECODER_UNIT_DEFINES_SVH
`define PALETTE_PIXEL_DECODER_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define PPD_CHECK(lbl, prop, msg) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error(msg);

// Same, but the property is an implication written as antecedent and consequent.
`define PPD_IMPLY(lbl, ante, cons, msg) `PPD_CHECK(lbl, (ante) |-> (cons), msg)

`endif

### design/ppd_pkg.sv
// Types, constants and codes for the palette pixel decoder.
package ppd_pkg;

	localparam int MAX_COLORS = 256;
	localparam int KEY_CHARS  = 2;
	localparam int KEY_BITS   = 8 * KEY_CHARS;
	localparam int IDX_W      = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
	localparam int CNT_W      = $clog2(MAX_COLORS + 1);
	localparam logic [CNT_W-1:0] NO_TRANS  = CNT_W'(MAX_COLORS);
	localparam logic [CNT_W-1:0] PAL_FULL  = CNT_W'(MAX_COLORS);

	// Gray: top three bits of floor(s / 1000) equal floor(s / 32000)
	localparam int GRAY_STEP  = 32000;
	localparam int GRAY_LEVELS = 7;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_ORIGIN    = 2'd0,
		REG_Y_ORIGIN    = 2'd1,
		REG_IMAGE_WIDTH = 2'd2,
		REG_GRAY_MODE   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_PAL   = 2'd1,
		OP_PIX   = 2'd2,
		OP_RSVD  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		TK_PAL = 2'd0,
		TK_PIX = 2'd1,
		TK_ERR = 2'd2
	} tok_kind_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] key;
		logic [23:0] rgb;
		logic        is_none;
	} item_t;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [31:0] pixel_color;
		logic        error;
	} result_t;

	// Token that travels down the cell chain.
	// idx: write slot for palette tokens, entry count for pixel tokens.
	typedef struct packed {
		logic             valid;
		tok_kind_t        kind;
		logic [15:0]      key;
		logic [23:0]      color;
		logic [CNT_W-1:0] idx;
		logic [CNT_W-1:0] trans;
		logic             found;
		logic             hit_trans;
		logic [11:0]      x;
		logic [11:0]      y;
	} tok_t;

	function automatic logic [15:0] key_mask(input logic [15:0] k);
		logic [15:0] m;
		m = 16'((32'd1 << KEY_BITS) - 32'd1);
		return k & m;
	endfunction

endpackage

### design/palette_pixel_decoder_unit.sv
// Top level of the palette pixel decoder: front end, chain of palette cells, result register.
//
//   channel  signals                          direction
//   item     in_valid / in_ready / item       in
//   result   out_valid / out_ready / result   out
//   config   cfg_we / cfg_idx / cfg_data      in (write only)
//
// One item per cycle enters while the result register is free or being drained.
// From transfer to result an item passes two front-end stages, one register per palette cell
// (the search walks the cell chain) and one result register.
// A stalled result freezes the whole chain; in_ready drops with it.
// Reset clears counters, origins, gray mode, valid flags; width resets to 1; slots stay unset.
module palette_pixel_decoder_unit import ppd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  item_t                 item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	tok_t    chain [MAX_COLORS+1];
	logic    adv, accept, emit;
	tok_t    last;
	logic    out_valid_q;
	result_t result_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign accept   = in_valid && adv;

	ppd_head u_head (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.accept   (accept),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.tok_o    (chain[0])
	);

	for (genvar i = 0; i < MAX_COLORS; i++) begin : g_cell
		ppd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.cell_idx (IDX_W'(i)),
			.tok_i    (chain[i]),
			.tok_o    (chain[i+1])
		);
	end

	always_comb begin
		last = chain[MAX_COLORS];
		emit = last.valid && ((last.kind == TK_ERR) ||
		       ((last.kind == TK_PIX) && last.found && !last.hit_trans));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q.pixel_x     <= last.x;
			result_q.pixel_y     <= last.y;
			result_q.error       <= (last.kind == TK_ERR);
			result_q.pixel_color <= (last.kind == TK_ERR) ? 32'd0 : {8'hFF, last.color};
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

### design/ppd_head.sv
// Front end: config registers, palette and raster counters, gray conversion, token build.
module ppd_head import ppd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  accept,
	input  item_t                 item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output tok_t                  tok_o
);

	logic [10:0] x_origin_q, y_origin_q;
	logic [11:0] image_width_q;
	logic        gray_mode_q;

	logic [CNT_W-1:0] entry_cnt_q, trans_q;
	logic [10:0]      col_q, row_q;

	// stage 1
	logic             valid_s1;
	tok_kind_t        kind_s1;
	logic [15:0]      key_s1;
	logic [23:0]      rgb_s1;
	logic [17:0]      sum_s1;
	logic             gray_s1;
	logic [CNT_W-1:0] idx_s1, trans_s1;
	logic [11:0]      x_s1, y_s1;

	// stage 2
	logic valid_s2;
	tok_t tok_s2;

	// accept-time logic
	opcode_t          op;
	logic [11:0]      w_eff, col_next;
	logic [23:0]      rgb_eff;
	logic [7:0]       r, g, b;
	logic [17:0]      sum;
	logic             pal_full;
	logic [2:0]       lvl;
	logic [7:0]       gray_v;
	logic [23:0]      color_s1;

	always_comb begin
		op       = opcode_t'(item.opcode);
		pal_full = (entry_cnt_q >= PAL_FULL);
		rgb_eff  = item.is_none ? 24'd0 : item.rgb;
		r = rgb_eff[23:16];
		g = rgb_eff[15:8];
		b = rgb_eff[7:0];
		sum = 18'(r) * 18'd299 + 18'(g) * 18'd587 + 18'(b) * 18'd114;
		if (image_width_q == 12'd0) begin
			w_eff = 12'd1;
		end else if (image_width_q > 12'd2048) begin
			w_eff = 12'd2048;
		end else begin
			w_eff = image_width_q;
		end
		col_next = {1'b0, col_q} + 12'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q    <= '0;
			y_origin_q    <= '0;
			image_width_q <= 12'd1;
			gray_mode_q   <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_X_ORIGIN:    x_origin_q    <= cfg_data[10:0];
				REG_Y_ORIGIN:    y_origin_q    <= cfg_data[10:0];
				REG_IMAGE_WIDTH: image_width_q <= cfg_data;
				REG_GRAY_MODE:   gray_mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_cnt_q <= '0;
			trans_q     <= NO_TRANS;
			col_q       <= '0;
			row_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			valid_s1 <= 1'b0;
			if (accept) begin
				case (op)
					OP_START: begin
						entry_cnt_q <= '0;
						trans_q     <= NO_TRANS;
						col_q       <= '0;
						row_q       <= '0;
					end
					OP_PAL: begin
						valid_s1 <= 1'b1;
						if (!pal_full) begin
							entry_cnt_q <= entry_cnt_q + CNT_W'(1);
							if (item.is_none) begin
								trans_q <= entry_cnt_q;
							end
						end
					end
					OP_PIX: begin
						valid_s1 <= 1'b1;
						if (col_next >= w_eff) begin
							col_q <= '0;
							row_q <= row_q + 11'd1;
						end else begin
							col_q <= col_next[10:0];
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && accept) begin
			key_s1   <= key_mask(item.key);
			rgb_s1   <= rgb_eff;
			sum_s1   <= sum;
			gray_s1  <= gray_mode_q;
			trans_s1 <= trans_q;
			if (op == OP_PIX) begin
				kind_s1 <= TK_PIX;
				idx_s1  <= entry_cnt_q;
				x_s1    <= 12'(x_origin_q) + 12'(col_q);
				y_s1    <= 12'(y_origin_q) + 12'(row_q);
			end else begin
				kind_s1 <= pal_full ? TK_ERR : TK_PAL;
				idx_s1  <= entry_cnt_q;
				x_s1    <= '0;
				y_s1    <= '0;
			end
		end
	end

	// quantized gray level: count of 32000 steps reached
	always_comb begin
		lvl = '0;
		for (int k = 1; k <= GRAY_LEVELS; k++) begin
			if (sum_s1 >= 18'(k * GRAY_STEP)) begin
				lvl = 3'(k);
			end
		end
		gray_v = {lvl, 5'd0};
		if (kind_s1 == TK_ERR) begin
			color_s1 = '0;
		end else if (gray_s1) begin
			color_s1 = {gray_v, gray_v, gray_v};
		end else begin
			color_s1 = rgb_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s2.valid     <= 1'b1;
			tok_s2.kind      <= kind_s1;
			tok_s2.key       <= key_s1;
			tok_s2.color     <= color_s1;
			tok_s2.idx       <= idx_s1;
			tok_s2.trans     <= trans_s1;
			tok_s2.found     <= 1'b0;
			tok_s2.hit_trans <= 1'b0;
			tok_s2.x         <= x_s1;
			tok_s2.y         <= y_s1;
		end
	end

	always_comb begin
		tok_o       = tok_s2;
		tok_o.valid = valid_s2;
	end

endmodule

### design/ppd_cell.sv
// One palette slot: holds a key and colour, writes or matches the passing token.
module ppd_cell import ppd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic [IDX_W-1:0] cell_idx,
	input  tok_t             tok_i,
	output tok_t             tok_o
);

	logic [15:0] key_q;
	logic [23:0] color_q;
	logic        valid_q;
	tok_t        pay_q;
	tok_t        nxt;
	logic [CNT_W-1:0] my_idx;
	logic        wr, hit;

	always_comb begin
		my_idx = CNT_W'(cell_idx);
		wr  = tok_i.valid && (tok_i.kind == TK_PAL) && (tok_i.idx == my_idx);
		// only slots below the token's entry count were written since start
		hit = tok_i.valid && (tok_i.kind == TK_PIX) && !tok_i.found &&
		      (my_idx < tok_i.idx) && (key_q == tok_i.key);
		nxt = tok_i;
		if (hit) begin
			nxt.found     = 1'b1;
			nxt.color     = color_q;
			nxt.hit_trans = (my_idx == tok_i.trans);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && wr) begin
			key_q   <= tok_i.key;
			color_q <= tok_i.color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= tok_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_q <= nxt;
		end
	end

	always_comb begin
		tok_o       = pay_q;
		tok_o.valid = valid_q;
	end

endmodule

### design/ppd_checker.sv
// Port-level checks on the palette pixel decoder, bound to the top level.
`include "palette_pixel_decoder_unit_defines.svh"

module ppd_checker import ppd_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    in_valid,
	input logic    in_ready,
	input logic    out_valid,
	input logic    out_ready,
	input result_t result
);

	`PPD_IMPLY(a_err_clean, out_valid && result.error, (result.pixel_x == 12'd0) && (result.pixel_y == 12'd0) && (result.pixel_color == 32'd0), "error result carries nonzero fields")
	`PPD_IMPLY(a_alpha, out_valid && !result.error, result.pixel_color[31:24] == 8'hFF, "pixel result without opaque alpha")
	`PPD_IMPLY(a_ready_free, !out_valid, in_ready, "input stalled with empty result register")
	`PPD_CHECK(a_hold, out_valid && !out_ready |=> out_valid && $stable(result), "stalled result changed")

endmodule

bind palette_pixel_decoder_unit ppd_checker u_ppd_checker (.*);
